[rtl/mdc_pkg.sv]
// Shared types, constants and the microprogram of the determinant block.
`timescale 1ns / 1ps

package mdc_pkg;

   // Fixed field widths of the external ports, the limb width and the lowest order.
   localparam int IN_W      = 16;
   localparam int CFG_W     = 3;
   localparam int DET_W     = 64;
   localparam int LIMB_W    = 32;
   localparam int MIN_ORDER = 2;

   localparam logic [CFG_W-1:0] SIZE_RESET = 3'd4;

   typedef logic [3:0] op_type;
   typedef logic [2:0] cond_type;
   typedef logic [3:0] step_type;

   // Datapath operations, one per microinstruction.
   localparam op_type OP_WAIT   = 4'd0;
   localparam op_type OP_INIT   = 4'd1;
   localparam op_type OP_READ   = 4'd2;
   localparam op_type OP_FACTOR = 4'd3;
   localparam op_type OP_MUL    = 4'd4;
   localparam op_type OP_ADD    = 4'd5;
   localparam op_type OP_NEXT   = 4'd6;
   localparam op_type OP_STORE  = 4'd7;
   localparam op_type OP_EMIT   = 4'd8;

   // Branch conditions tested by the sequencer.
   localparam cond_type C_ALWAYS     = 3'd0;
   localparam cond_type C_LOADED     = 3'd1;
   localparam cond_type C_MEMBER     = 3'd2;
   localparam cond_type C_MORE_LIMBS = 3'd3;
   localparam cond_type C_MORE_COLS  = 3'd4;
   localparam cond_type C_MORE_SETS  = 3'd5;
   localparam cond_type C_OUT_FREE   = 3'd6;

   // Microprogram addresses.
   localparam step_type ST_WAIT   = 4'd0;
   localparam step_type ST_INIT   = 4'd1;
   localparam step_type ST_PICK   = 4'd2;
   localparam step_type ST_FACTOR = 4'd3;
   localparam step_type ST_MUL    = 4'd4;
   localparam step_type ST_ADD    = 4'd5;
   localparam step_type ST_NEXT   = 4'd6;
   localparam step_type ST_STORE  = 4'd7;
   localparam step_type ST_EMIT   = 4'd8;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type on_true;
      step_type on_false;
   } ctrl_word_type;

   typedef struct packed {
      logic member;
      logic more_limbs;
      logic more_cols;
      logic more_sets;
   } dp_flags_type;

   // Control store. Each set of columns is visited in increasing order; each
   // member column adds one signed cofactor term, one 32-bit limb at a time.
   function automatic ctrl_word_type mdc_rom(input step_type step);
      ctrl_word_type word;
      unique case (step)
         ST_WAIT:   word = '{OP_WAIT,   C_LOADED,     ST_INIT,   ST_WAIT};
         ST_INIT:   word = '{OP_INIT,   C_ALWAYS,     ST_PICK,   ST_PICK};
         ST_PICK:   word = '{OP_READ,   C_MEMBER,     ST_FACTOR, ST_NEXT};
         ST_FACTOR: word = '{OP_FACTOR, C_ALWAYS,     ST_MUL,    ST_MUL};
         ST_MUL:    word = '{OP_MUL,    C_ALWAYS,     ST_ADD,    ST_ADD};
         ST_ADD:    word = '{OP_ADD,    C_MORE_LIMBS, ST_MUL,    ST_NEXT};
         ST_NEXT:   word = '{OP_NEXT,   C_MORE_COLS,  ST_PICK,   ST_STORE};
         ST_STORE:  word = '{OP_STORE,  C_MORE_SETS,  ST_PICK,   ST_EMIT};
         ST_EMIT:   word = '{OP_EMIT,   C_OUT_FREE,   ST_WAIT,   ST_EMIT};
         default:   word = '{OP_WAIT,   C_ALWAYS,     ST_WAIT,   ST_WAIT};
      endcase
      return word;
   endfunction

endpackage

[rtl/mdc_sequencer.sv]
// Microprogram sequencer: step counter, control store and branch logic.
`timescale 1ns / 1ps

module mdc_sequencer
   import mdc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  dp_flags_type dp_flags,
   input  logic         loaded,
   input  logic         out_free,
   output op_type       op
);

   step_type      step_ff;
   step_type      step_in;
   ctrl_word_type word;
   logic          taken;

   // Fetch the control word and pick the branch target.
   always_comb begin
      word = mdc_rom(step_ff);
      unique case (word.cond)
         C_ALWAYS:     taken = 1'b1;
         C_LOADED:     taken = loaded;
         C_MEMBER:     taken = dp_flags.member;
         C_MORE_LIMBS: taken = dp_flags.more_limbs;
         C_MORE_COLS:  taken = dp_flags.more_cols;
         C_MORE_SETS:  taken = dp_flags.more_sets;
         C_OUT_FREE:   taken = out_free;
         default:      taken = 1'b1;
      endcase
      step_in = taken ? word.on_true : word.on_false;
   end

   assign op = word.op;

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

[rtl/mdc_datapath.sv]
// Datapath: element store, minor table, limb multiplier and accumulator.
`timescale 1ns / 1ps

module mdc_datapath
   import mdc_pkg::*;
#(
   parameter int MAX_SIZE      = 4,
   parameter int ELEMENT_WIDTH = 16,
   localparam int ORD_W  = $clog2(MAX_SIZE + 1),
   localparam int DEPTH  = MAX_SIZE * MAX_SIZE,
   localparam int ADDR_W = $clog2(DEPTH)
)
(
   input  logic                            clock,
   input  op_type                          op,
   input  logic [ORD_W-1:0]                order,
   input  logic                            st_we,
   input  logic [ADDR_W-1:0]               st_addr,
   input  logic signed [ELEMENT_WIDTH-1:0] st_data,
   output dp_flags_type                    dp_flags,
   output logic signed [DET_W-1:0]         det,
   output logic                            sat
);

   localparam int COL_W   = $clog2(MAX_SIZE);
   localparam int SET_W   = MAX_SIZE;
   localparam int SETS    = 1 << MAX_SIZE;
   localparam int EXACT_W = ELEMENT_WIDTH * MAX_SIZE + 8;
   localparam int ACC_W   = (EXACT_W > DET_W + 1) ? EXACT_W : DET_W + 1;
   localparam int LIMBS   = (ACC_W + LIMB_W - 1) / LIMB_W;
   localparam int LIMB_IW = $clog2(LIMBS);
   localparam int PAD_W   = LIMBS * LIMB_W;
   localparam int FAC_W   = ELEMENT_WIDTH + 1;
   localparam int PP_W    = LIMB_W + 1 + FAC_W;
   localparam int ROWB_W  = 2 * ORD_W;

   // Memories: matrix elements and determinants of minors indexed by column set.
   logic signed [ELEMENT_WIDTH-1:0] elem_mem [DEPTH];
   logic        [ACC_W-1:0]         d_mem    [SETS];

   logic [SET_W-1:0]         set_ff, set_in;
   logic [COL_W-1:0]         col_ff, col_in;
   logic                     par_ff, par_in;
   logic [LIMB_IW-1:0]       limb_ff, limb_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic signed [FAC_W-1:0]  fac_ff, fac_in;
   logic signed [PP_W-1:0]   pp_ff, pp_in;
   logic signed [ELEMENT_WIDTH-1:0] elem_rd_ff;
   logic [ACC_W-1:0]         dop_ff;

   logic [ORD_W-1:0]         ones;
   logic [ORD_W-1:0]         row;
   logic [ROWB_W-1:0]        row_base;
   logic [ADDR_W-1:0]        elem_addr;
   logic [SET_W-1:0]         dop_addr;
   logic [SET_W-1:0]         full_set;
   logic [PAD_W-1:0]         dop_pad;
   logic [LIMB_W-1:0]        limb_sel;
   logic signed [FAC_W-1:0]  el_ext;
   logic signed [ACC_W-1:0]  pp_ext;
   logic [ACC_W-1:0]         addend;
   logic                     member;
   logic                     more_sets;
   logic                     fits;

   // The row in use is the first row of the minor: order minus the set size.
   always_comb begin
      ones = '0;
      for (int i = 0; i < MAX_SIZE; i++) begin
         ones = ones + ORD_W'(set_ff[i]);
      end
   end

   assign row       = order - ones;
   assign row_base  = ROWB_W'(row) * ROWB_W'(order);
   assign elem_addr = ADDR_W'(row_base + ROWB_W'(col_ff));
   assign dop_addr  = set_ff & ~(SET_W'(1) << col_ff);
   assign full_set  = SET_W'((1 << order) - 1);

   // Branch flags for the sequencer.
   assign member    = set_ff[col_ff];
   assign more_sets = set_ff != full_set;

   assign dp_flags.member     = member;
   assign dp_flags.more_limbs = limb_ff != LIMB_IW'(LIMBS - 1);
   assign dp_flags.more_cols  = ORD_W'(col_ff) != order - ORD_W'(1);
   assign dp_flags.more_sets  = more_sets;

   // Limb select and shifted partial product.
   assign dop_pad  = PAD_W'(dop_ff);
   assign limb_sel = dop_pad[limb_ff * LIMB_W +: LIMB_W];
   assign el_ext   = FAC_W'(elem_rd_ff);
   assign pp_ext   = ACC_W'(pp_ff);
   assign addend   = pp_ext << (limb_ff * LIMB_W);

   // Next values of the working registers, decoded from the operation.
   always_comb begin
      set_in  = set_ff;
      col_in  = col_ff;
      par_in  = par_ff;
      limb_in = limb_ff;
      acc_in  = acc_ff;
      fac_in  = fac_ff;
      pp_in   = pp_ff;
      unique case (op)
         OP_INIT: begin
            set_in = SET_W'(1);
            col_in = '0;
            par_in = 1'b0;
            acc_in = '0;
         end
         OP_FACTOR: begin
            fac_in  = par_ff ? -el_ext : el_ext;
            limb_in = '0;
         end
         OP_MUL: begin
            pp_in = $signed({1'b0, limb_sel}) * fac_ff;
         end
         OP_ADD: begin
            acc_in  = acc_ff + addend;
            limb_in = limb_ff + LIMB_IW'(1);
         end
         OP_NEXT: begin
            par_in = par_ff ^ member;
            col_in = col_ff + COL_W'(1);
         end
         OP_STORE: begin
            if (more_sets) begin
               set_in = set_ff + SET_W'(1);
               col_in = '0;
               par_in = 1'b0;
               acc_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      set_ff  <= set_in;
      col_ff  <= col_in;
      par_ff  <= par_in;
      limb_ff <= limb_in;
      acc_ff  <= acc_in;
      fac_ff  <= fac_in;
      pp_ff   <= pp_in;
   end

   // Element store: written on each input transfer, read with a register.
   always_ff @(posedge clock) begin
      if (st_we) begin
         elem_mem[st_addr] <= st_data;
      end
      if (op == OP_READ) begin
         elem_rd_ff <= elem_mem[elem_addr];
      end
   end

   // Minor table: the empty set holds one, each finished set stores its sum.
   always_ff @(posedge clock) begin
      if (op == OP_INIT) begin
         d_mem[SET_W'(0)] <= ACC_W'(1);
      end else if (op == OP_STORE) begin
         d_mem[set_ff] <= acc_ff;
      end
      if (op == OP_READ) begin
         dop_ff <= d_mem[dop_addr];
      end
   end

   // Saturate the exact sum to 64 bits.
   assign fits = (&acc_ff[ACC_W-1:DET_W-1]) | ~(|acc_ff[ACC_W-1:DET_W-1]);
   assign sat  = ~fits;
   assign det  = fits ? $signed(acc_ff[DET_W-1:0]) :
                 acc_ff[ACC_W-1] ? $signed({1'b1, {(DET_W-1){1'b0}}}) :
                                   $signed({1'b0, {(DET_W-1){1'b1}}});

endmodule

[rtl/matrix_determinant_cofactor.sv]
// After the last element the microprogram computes the result, stepped by the
// single 32-bit limb multiply-accumulate; further elements are stalled until
// the result is emitted. Elements are taken one per cycle while loading, also
// while a result waits to be taken.
// Reset is synchronous: order register to 4, load count and result valid cleared.
`timescale 1ns / 1ps

module matrix_determinant_cofactor
   import mdc_pkg::*;
#(
   parameter int MAX_SIZE      = 4,
   parameter int ELEMENT_WIDTH = 16
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CFG_W-1:0]         csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [IN_W-1:0]   req_element_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DET_W-1:0]  rsp_determinant,
   output logic                     rsp_saturated
);

   localparam int ORD_W  = $clog2(MAX_SIZE + 1);
   localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   logic [CFG_W-1:0]        size_ff, size_in;
   logic [CNT_W-1:0]        load_count_ff, load_count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [DET_W-1:0] det_ff, det_in;
   logic                    sat_ff, sat_in;

   logic [ORD_W-1:0]        order;
   logic [CNT_W-1:0]        total;
   logic                    req_accept;
   logic                    last;
   logic                    loaded;
   logic                    out_free;
   logic                    emit;
   op_type                  op;
   dp_flags_type            dp_flags;
   logic signed [DET_W-1:0] det;
   logic                    sat;

   // Order in use, clamped to the supported range.
   always_comb begin
      if (size_ff < CFG_W'(MIN_ORDER)) begin
         order = ORD_W'(MIN_ORDER);
      end else if (int'(size_ff) > MAX_SIZE) begin
         order = ORD_W'(MAX_SIZE);
      end else begin
         order = ORD_W'(size_ff);
      end
   end

   assign total = CNT_W'(int'(order) * int'(order));

   // Input transfers are taken only while the sequencer waits for elements.
   assign req_stall  = op != OP_WAIT;
   assign req_accept = req_valid & ~req_stall;
   assign last       = load_count_ff == total - CNT_W'(1);
   assign loaded     = req_accept & last;

   // The output register is free when empty or being transferred now.
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign emit     = (op == OP_EMIT) & out_free;

   // Order register and load counter; a register write drops a partial load.
   always_comb begin
      size_in       = size_ff;
      load_count_in = load_count_ff;
      if (csr_wr_en) begin
         size_in       = csr_wr_data;
         load_count_in = '0;
      end else if (req_accept) begin
         load_count_in = last ? '0 : load_count_ff + CNT_W'(1);
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      det_in       = det_ff;
      sat_in       = sat_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         det_in       = det;
         sat_in       = sat;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff       <= SIZE_RESET;
         load_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         size_ff       <= size_in;
         load_count_ff <= load_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      det_ff <= det_in;
      sat_ff <= sat_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_determinant = det_ff;
   assign rsp_saturated   = sat_ff;

   mdc_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .dp_flags (dp_flags),
      .loaded   (loaded),
      .out_free (out_free),
      .op       (op)
   );

   mdc_datapath #(
      .MAX_SIZE      (MAX_SIZE),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .op       (op),
      .order    (order),
      .st_we    (req_accept),
      .st_addr  (load_count_ff[ADDR_W-1:0]),
      .st_data  ($signed(req_element_value[ELEMENT_WIDTH-1:0])),
      .dp_flags (dp_flags),
      .det      (det),
      .sat      (sat)
   );

   // A result appears only out of the emit step of the microprogram.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(op == OP_EMIT))
      else $error("result valid rose outside the emit step");

   // The load counter never reaches the element count of the current order.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      load_count_ff < total)
      else $error("load count out of range");

   // While the determinant is being computed no partial load is pending.
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      op != OP_WAIT |-> load_count_ff == '0)
      else $error("elements pending while computing");

endmodule

[sim/tb.sv]
// Self-checking testbench for the cofactor-expansion determinant block.
`timescale 1ns / 1ps

module tb;
   import mdc_pkg::*;

   localparam int MAX_ORDER       = 4;
   localparam int SETTLE_CYCLES   = 400;     // idle wait after the last due determinant
   localparam int DRAIN_LIMIT     = 20000;
   localparam int CYCLE_LIMIT     = 800000;
   localparam int RANDOM_ELEMENTS = 900;
   localparam int HOLD_OFF_CYCLES = 2500;

   typedef logic signed [127:0] exact_type;

   typedef struct {
      logic signed [DET_W-1:0] value;
      logic                    sat;
   } det_result_type;

   typedef enum {FILL_FULL, FILL_SMALL, FILL_EDGE, FILL_MIXED} fill_style_type;
   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    csr_wr_en = 1'b0;
   logic [CFG_W-1:0]        csr_wr_data = SIZE_RESET;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [IN_W-1:0]  req_element_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [DET_W-1:0] rsp_determinant;
   logic                    rsp_saturated;

   // Shadow copy of the block state used for prediction.
   logic [CFG_W-1:0] order_setting = SIZE_RESET;
   int               element_mem [MAX_ORDER*MAX_ORDER];
   int               fill_count = 0;
   det_result_type   pending_dets [$];

   int cycle_count = 0;
   int mismatch_count = 0;
   int elements_sent = 0;
   int dets_checked = 0;
   int saturations_seen = 0;
   int input_stall_cycles = 0;

   // Sender pacing and the receiver hold-off request.
   bit pacing_on = 1'b1;
   int burst_left = 0;
   int hold_cycles = 0;

   matrix_determinant_cofactor #(
      .MAX_SIZE      (MAX_ORDER),
      .ELEMENT_WIDTH (IN_W)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_determinant   (rsp_determinant),
      .rsp_saturated     (rsp_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Cycle counter with a hard stop for a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d determinants still due",
                  cycle_count, pending_dets.size());
         $display("tb NOT OK");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [DET_W-1:0] got,
                                  input logic [DET_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("mismatch at cycle %0d: %s: got %h, want %h", cycle_count, what, got, want);
   endtask

   function automatic int order_in_effect(input logic [CFG_W-1:0] setting);
      if (setting < MIN_ORDER)
         return MIN_ORDER;
      if (setting > MAX_ORDER)
         return MAX_ORDER;
      return int'(setting);
   endfunction

   // Exact 3x3 determinant; every term fits in 64 bits for 16-bit entries.
   function automatic longint det3(input int t [9]);
      return longint'(t[0]) * (longint'(t[4]) * t[8] - longint'(t[7]) * t[5])
           - longint'(t[1]) * (longint'(t[3]) * t[8] - longint'(t[6]) * t[5])
           + longint'(t[2]) * (longint'(t[3]) * t[7] - longint'(t[6]) * t[4]);
   endfunction

   // Exact determinant of the loaded matrix, expanded along the first row.
   function automatic exact_type loaded_det(input int n);
      int        minor [9];
      exact_type acc;
      exact_type term;
      int        k, col, r, c;
      acc = '0;
      if (n == 2) begin
         acc = exact_type'(longint'(element_mem[0]) * element_mem[3]
                         - longint'(element_mem[2]) * element_mem[1]);
      end else if (n == 3) begin
         for (k = 0; k < 9; k++)
            minor[k] = element_mem[k];
         acc = exact_type'(det3(minor));
      end else begin
         for (col = 0; col < 4; col++) begin
            k = 0;
            for (r = 1; r < 4; r++)
               for (c = 0; c < 4; c++)
                  if (c != col) begin
                     minor[k] = element_mem[r*4 + c];
                     k++;
                  end
            term = exact_type'(det3(minor));
            term = term * element_mem[col];
            acc = (col % 2 == 1) ? acc - term : acc + term;
         end
      end
      return acc;
   endfunction

   // Load one element into the shadow store; a completed matrix queues its determinant.
   task automatic predict_element(input logic signed [IN_W-1:0] value);
      int             n;
      exact_type      exact;
      det_result_type result;
      n = order_in_effect(order_setting);
      if (fill_count >= n*n)
         fill_count = 0;
      element_mem[fill_count] = int'(value);
      fill_count++;
      if (fill_count == n*n) begin
         fill_count = 0;
         exact = loaded_det(n);
         result.sat = (exact[127:DET_W-1] != {(128-DET_W+1){exact[DET_W-1]}});
         if (!result.sat)
            result.value = exact[DET_W-1:0];
         else if (exact[127])
            result.value = {1'b1, {(DET_W-1){1'b0}}};
         else
            result.value = {1'b0, {(DET_W-1){1'b1}}};
         pending_dets.push_back(result);
      end
   endtask

   // Offer one element and wait for its transfer; gaps fall between bursts.
   task automatic send_element(input logic signed [IN_W-1:0] value);
      if (pacing_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0)
         burst_left--;
      req_valid <= 1'b1;
      req_element_value <= value;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      elements_sent++;
      predict_element(value);
   endtask

   task automatic send_2x2(input int a, input int b, input int c, input int d);
      send_element(IN_W'(a));
      send_element(IN_W'(b));
      send_element(IN_W'(c));
      send_element(IN_W'(d));
   endtask

   // Stop offering, wait for every due determinant, then let the block settle.
   task automatic wait_for_idle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_dets.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_dets.size() != 0) begin
         report_mismatch("determinants never delivered", DET_W'(pending_dets.size()), '0);
         pending_dets.delete();
      end
   endtask

   // A write to the order register also drops any partly loaded matrix.
   task automatic write_order(input logic [CFG_W-1:0] setting);
      wait_for_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= setting;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      order_setting = setting;
      fill_count = 0;
   endtask

   function automatic logic signed [IN_W-1:0] random_element(input fill_style_type style);
      fill_style_type pick;
      pick = style;
      if (pick == FILL_MIXED)
         pick = fill_style_type'($urandom_range(0, 2));
      case (pick)
         FILL_SMALL: random_element = IN_W'($urandom_range(0, 14) - 7);
         FILL_EDGE: begin
            case ($urandom_range(0, 3))
               0: random_element = 16'sh8000;
               1: random_element = 16'sh7FFF;
               2: random_element = '0;
               default: random_element = '1;
            endcase
         end
         default: random_element = IN_W'($urandom);
      endcase
   endfunction

   // Receiver: stall on a changing pattern, or hold off for a requested stretch.
   initial begin : receiver
      stall_mode_type mode;
      int             mode_left;
      int             held;
      mode = STALL_NONE;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            held = hold_cycles;
            rsp_stall <= 1'b1;
            repeat (held) @(posedge clock);
            hold_cycles = 0;
         end else begin
            if (mode_left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 7) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 0);
               default:     rsp_stall <= (mode_left % 3 != 0);
            endcase
         end
      end
   end

   // Compare each result transfer with the oldest predicted determinant.
   always @(posedge clock) begin : result_check
      det_result_type want;
      if (!reset) begin
         if (req_valid && req_stall === 1'b1)
            input_stall_cycles++;
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_dets.size() == 0) begin
               report_mismatch("result with nothing due", rsp_determinant, '0);
            end else begin
               want = pending_dets.pop_front();
               if (rsp_determinant !== want.value)
                  report_mismatch("determinant", rsp_determinant, want.value);
               if (rsp_saturated !== want.sat)
                  report_mismatch("saturated flag", DET_W'(rsp_saturated), DET_W'(want.sat));
               dets_checked++;
               if (want.sat)
                  saturations_seen++;
            end
         end
      end
   end

   // Scaled Hadamard matrices at the reset order of 4 and at an order above range.
   task automatic test_overflow();
      int r, c, row;
      for (r = 0; r < 4; r++)
         for (c = 0; c < 4; c++)
            send_element(IN_W'(($countones(r & c) % 2 == 1) ? -32767 : 32767));
      write_order(3'd5);
      // Swapping the first two rows flips the sign of the determinant.
      for (r = 0; r < 4; r++) begin
         row = (r == 0) ? 1 : (r == 1) ? 0 : r;
         for (c = 0; c < 4; c++)
            send_element(IN_W'(($countones(row & c) % 2 == 1) ? -32767 : 32767));
      end
   endtask

   // Orders below range run as 2x2 matrices; field extremes go through here.
   task automatic test_order_clamp();
      write_order(3'd1);
      send_2x2(-32768, -32768, 32767, -32768);
      send_2x2(32767, -32768, 32767, -32768);
      write_order(3'd0);
      send_2x2(0, -1, 1, 0);
   endtask

   // A new order written during a load drops the partial matrix.
   task automatic test_reload_midway();
      int i;
      write_order(3'd3);
      for (i = 0; i < 5; i++)
         send_element(random_element(FILL_FULL));
      write_order(3'd2);
      send_2x2(7, 3, 2, 5);
   endtask

   // The receiver holds off long enough for the block to stall its input.
   task automatic test_backpressure();
      int i;
      wait_for_idle();
      pacing_on = 1'b0;
      hold_cycles = HOLD_OFF_CYCLES;
      for (i = 0; i < 16; i++)
         send_element(random_element(FILL_FULL));
      pacing_on = 1'b1;
      wait_for_idle();
   endtask

   // Phases at each order setting, then at random orders: mostly whole matrices, a few cut short.
   task automatic test_random_matrices();
      int               start, phase, pick, n, m, count, matrices, i;
      logic [CFG_W-1:0] setting;
      fill_style_type   style;
      start = elements_sent;
      phase = 0;
      while (elements_sent - start < RANDOM_ELEMENTS) begin
         if (phase < 8) begin
            setting = CFG_W'(phase);
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
               setting = CFG_W'($urandom_range(0, 2));
            else if (pick < 8)
               setting = 3'd3;
            else
               setting = CFG_W'($urandom_range(4, 7));
         end
         write_order(setting);
         pacing_on = ($urandom_range(0, 3) != 0);
         n = order_in_effect(setting);
         matrices = $urandom_range(1, 6);
         for (m = 0; m < matrices; m++) begin
            style = fill_style_type'($urandom_range(0, 3));
            count = n*n;
            // An occasional broken load, dropped by the next order write.
            if ($urandom_range(0, 9) == 0)
               count = $urandom_range(1, n*n - 1);
            for (i = 0; i < count; i++)
               send_element(random_element(style));
            if (count < n*n)
               break;
         end
         phase++;
      end
      pacing_on = 1'b1;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_overflow();
      test_order_clamp();
      test_reload_midway();
      test_backpressure();
      test_random_matrices();
      wait_for_idle();
      $display("sent %0d elements at orders 2 to 4 and all eight order settings,",
               elements_sent);
      $display("checked %0d determinants (%0d saturated), input held off %0d cycles",
               dets_checked, saturations_seen, input_stall_cycles);
      if (mismatch_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
